@@ hdl/adcma_pkg.sv @@
// Shared types and constants for the converter moving-average block.
`default_nettype none

package adcma_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int SECONDS_W = 16;
  localparam int COUNT_W   = 16;

  localparam logic [SAMPLE_W-1:0] SIGN_FLIP   = 24'h800000;
  localparam logic [COUNT_W-1:0]  COUNTER_MAX = 16'hFFFF;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  raw_sample;
    logic [SECONDS_W-1:0] seconds_now;
  } req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] offset_sample;
    logic [SAMPLE_W-1:0] filtered_value;
    logic [COUNT_W-1:0]  rate_samples;
    logic                rate_updated;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/adc_moving_average_rate.sv @@
// Top level: moving-average filter and sample-rate meter for a 24-bit converter.
//
// Usage: each request on the req channel carries one converter word
// (two's complement) and the current whole-seconds count. Exactly one
// result leaves on the res channel per request, in order: the word in
// offset binary, the average of the last WINDOW_LEN samples, the sample
// rate of the last completed second and a flag that marks a closed second.
// Both channels use valid/ready; an item moves when both are high.
// Path: an accepted request is held in stage one and then in the result
// register, where it waits until the receiver takes it. Throughput: one
// request per cycle while res_ready stays high, set by the running-sum
// update and the cell-chain shift on each accepted request; the divide
// is a shift or one constant multiply between the sum register and the
// result register.
// Reset: synchronous, clears every window cell, the running sum, the
// counters and both pipeline stages at once; no clearing pass follows.
// Stall: when res_ready is low the result holds, stage one keeps
// one more item, and req_ready drops only when both stages are full.
`default_nettype none

module adc_moving_average_rate
  import adcma_pkg::*;
#(
  parameter int WINDOW_LEN = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);

  // Pipeline handshake: the result register loads when empty or drained,
  // stage one advances into it, and a request enters behind it.
  logic s1_valid;
  logic out_load;
  logic accept;

  assign out_load  = !res_valid || res_ready;
  assign req_ready = !s1_valid || out_load;
  assign accept    = req_valid && req_ready;

  // Cell chain: the newest sample enters at tap zero, the oldest leaves
  // at the far end. This matches the ring buffer, since the slot that is
  // overwritten always holds the sample taken WINDOW_LEN requests ago.
  sample_t sample_new;
  sample_t tap [WINDOW_LEN+1];

  assign sample_new = req.raw_sample ^ SIGN_FLIP;
  assign tap[0]     = sample_new;

  generate
    for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
      adcma_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .d     (tap[k]),
        .q     (tap[k+1])
      );
    end
  endgenerate

  // Running sum: drop the oldest sample, add the newest.
  logic [SUM_W-1:0] window_sum;
  logic [SUM_W-1:0] window_sum_next;

  assign window_sum_next = window_sum - SUM_W'(tap[WINDOW_LEN]) + SUM_W'(sample_new);

  // Rate meter: count every sample, saturate, and report on a new second.
  logic [COUNT_W-1:0]   sample_counter;
  logic [COUNT_W-1:0]   counter_inc;
  logic [SECONDS_W-1:0] last_seconds;
  logic [COUNT_W-1:0]   rate_register;
  logic                 second_closed;

  assign counter_inc   = (sample_counter < COUNTER_MAX) ? sample_counter + 1'b1
                                                        : sample_counter;
  assign second_closed = (req.seconds_now != last_seconds);

  // Stage one payload; its sum is window_sum, which only changes when
  // this stage takes a new item.
  sample_t            s1_offset;
  logic [COUNT_W-1:0] s1_rate;
  logic               s1_updated;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum     <= '0;
      sample_counter <= '0;
      last_seconds   <= '0;
      rate_register  <= '0;
      s1_valid       <= 1'b0;
    end else begin
      if (accept) begin
        window_sum <= window_sum_next;
        if (second_closed) begin
          last_seconds   <= req.seconds_now;
          rate_register  <= counter_inc;
          sample_counter <= '0;
        end else begin
          sample_counter <= counter_inc;
        end
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_offset  <= sample_new;
      s1_rate    <= second_closed ? counter_inc : rate_register;
      s1_updated <= second_closed;
    end
  end

  // Divide the held sum on the way into the result register.
  sample_t quotient;

  adcma_divider #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_divider (
    .sum      (window_sum),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      res.offset_sample  <= s1_offset;
      res.filtered_value <= quotient;
      res.rate_samples   <= s1_rate;
      res.rate_updated   <= s1_updated;
    end
  end

endmodule

`default_nettype wire

@@ hdl/adcma_cell.sv @@
// One window cell: holds a sample and hands it to its neighbor on each shift.
`default_nettype none

module adcma_cell
  import adcma_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    shift,
  input  sample_t d,
  output sample_t q
);

  sample_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (shift) begin
      slot <= d;
    end
  end

  assign q = slot;

endmodule

`default_nettype wire

@@ hdl/adcma_divider.sv @@
// Divide the window sum by the constant window length.
`default_nettype none

module adcma_divider
  import adcma_pkg::*;
#(
  parameter int WINDOW_LEN = 16,
  parameter int SUM_W      = 28
) (
  input  logic [SUM_W-1:0] sum,
  output sample_t          quotient
);

  localparam int LOG_N = $clog2(WINDOW_LEN);

  generate
    if ((WINDOW_LEN & (WINDOW_LEN - 1)) == 0) begin : g_shift
      logic [SUM_W-1:0] shifted;
      assign shifted  = sum >> LOG_N;
      assign quotient = shifted[SAMPLE_W-1:0];
    end else begin : g_recip
      // Round the reciprocal up; the error stays below one quotient step
      // for every sum that fits in SUM_W bits.
      localparam int SH = SUM_W + LOG_N;
      localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
      localparam logic [SUM_W:0] RECIP = RECIP_WIDE[SUM_W:0];
      logic [2*SUM_W+1:0] product;
      assign product  = {1'b0, sum} * RECIP;
      assign quotient = product[SH +: SAMPLE_W];
    end
  endgenerate

endmodule

`default_nettype wire

@@ hdl/adcma_checker.sv @@
// Port-level checks for the converter moving-average block, bound to its top level.
`default_nettype none

module adcma_checker
  import adcma_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  // Hold a stalled result.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed or dropped");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // An accepted request reaches the output via stage one when res_ready is high while it sits there.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) ##1 (res_ready && !rst) |=> res_valid)
    else $error("result missing two cycles after request");

  // That result carries the offset-binary form of the request's word.
  a_offset: assert property (@(posedge clk) disable iff (rst)
    res_valid && $past(req_valid && req_ready && !rst, 2)
      && $past(res_ready && !rst, 1)
    |-> res.offset_sample == ($past(req.raw_sample, 2) ^ SIGN_FLIP))
    else $error("offset sample does not match request");

endmodule

bind adc_moving_average_rate adcma_checker u_adcma_checker (.*);

`default_nettype wire

@@ bench/adc_moving_average_rate_test.sv @@
// Self-checking bench for the converter moving-average filter and rate meter.
module adc_moving_average_rate_test;
  timeunit 1ns;
  timeprecision 1ps;

  import adcma_pkg::*;

  localparam int WINDOW_LEN     = 16;
  localparam int SUM_W          = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int MAX_WAIT       = 13;     // longest per-request gap or stall
  localparam int LONG_HOLD      = 90;     // receiver hold-off that backs up the block
  localparam int WATCHDOG_LIMIT = 3000;   // cycles without any handshake
  localparam int MAX_REPORTS    = 40;
  localparam int SEGMENTS       = 13;
  localparam int SEGMENT_LEN    = 50;

  typedef struct {
    req_t        data;
    int unsigned gap;
  } feed_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  // Stimulus waiting to be driven, and results the block still owes us.
  feed_item_t feed_q[$];
  res_t       owed_results[$];

  // Shadow of the block: ring of offset samples, running sum, rate meter.
  sample_t              ring [WINDOW_LEN];
  logic [SUM_W-1:0]     ring_sum = '0;
  int unsigned          ring_pos = 0;
  logic [COUNT_W-1:0]   count_in_second = '0;
  logic [SECONDS_W-1:0] prev_seconds = '0;
  logic [COUNT_W-1:0]   rate_now = '0;

  // Handshake bookkeeping between the clocked processes.
  logic        req_taken = 1'b0;
  logic        res_taken = 1'b0;
  feed_item_t  next_item;
  int unsigned gap_left = 0;
  logic        gap_armed = 1'b0;
  int unsigned sink_wait = 0;
  logic        sink_calm = 1'b0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;

  // Run statistics.
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned seconds_closed = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  adc_moving_average_rate #(
    .WINDOW_LEN(WINDOW_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Advance the shadow state by one sample and return the result it must produce.
  // The ring position moves before the slot is replaced, so the first sample
  // after reset lands in slot 1; the counter saturates rather than wrapping.
  function automatic res_t filter_sample(req_t r);
    res_t    o;
    sample_t s;
    s = r.raw_sample ^ SIGN_FLIP;
    ring_pos = (ring_pos == WINDOW_LEN - 1) ? 0 : ring_pos + 1;
    ring_sum = ring_sum - ring[ring_pos] + s;
    ring[ring_pos] = s;
    if (count_in_second != COUNTER_MAX)
      count_in_second++;
    o.rate_updated = 1'b0;
    if (r.seconds_now != prev_seconds) begin
      prev_seconds = r.seconds_now;
      rate_now = count_in_second;
      count_in_second = '0;
      o.rate_updated = 1'b1;
      seconds_closed++;
    end
    o.offset_sample  = s;
    o.filtered_value = sample_t'(ring_sum / WINDOW_LEN);
    o.rate_samples   = rate_now;
    return o;
  endfunction

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    else if (mismatches == MAX_REPORTS + 1)
      $display("%0t: further mismatch reports suppressed", $time);
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (owed_results.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected, got %h", $time, got);
    end else begin
      want = owed_results.pop_front();
      if (got.offset_sample !== want.offset_sample)
        report_field("offset_sample", 32'(want.offset_sample), 32'(got.offset_sample));
      if (got.filtered_value !== want.filtered_value)
        report_field("filtered_value", 32'(want.filtered_value), 32'(got.filtered_value));
      if (got.rate_samples !== want.rate_samples)
        report_field("rate_samples", 32'(want.rate_samples), 32'(got.rate_samples));
      if (got.rate_updated !== want.rate_updated)
        report_field("rate_updated", 32'(want.rate_updated), 32'(got.rate_updated));
    end
  endtask

  task automatic queue_request(sample_t raw, logic [SECONDS_W-1:0] secs, int unsigned gap);
    feed_item_t item;
    item.data.raw_sample  = raw;
    item.data.seconds_now = secs;
    item.gap = gap;
    feed_q.push_back(item);
  endtask

  // Hold the sender until every queued request is in and every result is out.
  task automatic wait_idle();
    while (feed_q.size() != 0 || req_valid || owed_results.size() != 0)
      @(posedge clk);
  endtask

  // Observe both channels at the rising edge. Predict on request acceptance,
  // check on result acceptance; the request is handled first in case the
  // block ever forwards a result in the same cycle.
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      owed_results.push_back(filter_sample(req));
      requests_sent++;
    end
    if (!rst && res_valid && res_ready) begin
      check_result(res);
      results_seen++;
    end
    req_taken <= !rst && req_valid && req_ready;
    res_taken <= !rst && res_valid && res_ready;
  end

  // Request driver: change inputs at the falling edge. Hold valid and payload
  // until the request is taken, then wait out the next item's gap before
  // offering it. A gap of zero keeps valid high across back-to-back requests.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_armed = 1'b0;
    end else if (!req_valid || req_taken) begin
      if (feed_q.size() == 0) begin
        req_valid <= 1'b0;
      end else begin
        if (!gap_armed) begin
          gap_left = feed_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else begin
          next_item = feed_q.pop_front();
          req <= next_item.data;
          req_valid <= 1'b1;
          gap_armed = 1'b0;
        end
      end
    end
  end

  // Result receiver: draw a random stall after every accepted result, or none
  // when sink_calm is set. A hold-off request from the stimulus process drops
  // ready for a long stretch so the block fills both stages and pushes back on the request side.
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        sink_wait = LONG_HOLD;
      end else if (res_taken) begin
        sink_wait = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      res_ready <= (sink_wait == 0);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [SECONDS_W-1:0] secs;
    sample_t              raw;
    logic                 feed_calm;
    int unsigned          pick;

    foreach (ring[k])
      ring[k] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: sample extremes within the reset second, closing seconds at
    // both ends of the seconds range, a repeated second, then a full window
    // of the largest offset value so the sum reaches its ceiling.
    sink_calm = 1'b0;
    queue_request(24'h000000, 16'h0000, 0);
    queue_request(24'h7FFFFF, 16'h0000, 3);
    queue_request(24'h800000, 16'h0000, 0);
    queue_request(24'hFFFFFF, 16'h0000, MAX_WAIT);
    queue_request(24'h000001, 16'h0001, 1);
    queue_request(24'hFFFFFE, 16'hFFFF, 0);
    queue_request(24'h400000, 16'hFFFF, 2);
    queue_request(24'hC00000, 16'h0000, 0);
    for (int i = 0; i < WINDOW_LEN; i++)
      queue_request(24'h7FFFFF, 16'h0000, (i % 3 == 0) ? 0 : $urandom_range(0, MAX_WAIT));
    wait_idle();

    // Random traffic in segments; some segments run without idling on either
    // side, one backs up the block with a long receiver hold-off, and a few
    // start only once the block has drained.
    secs = SECONDS_W'($urandom);
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 6 || seg == 9)
        wait_idle();
      feed_calm = (seg == 6) || ($urandom_range(0, 3) == 0);
      sink_calm = feed_calm;
      if (seg == 4)
        secs = 16'hFFFD;
      for (int i = 0; i < SEGMENT_LEN; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 12)
          secs++;
        else if (pick < 14)
          secs = SECONDS_W'($urandom);
        case ($urandom_range(0, 9))
          0:       raw = 24'h000000;
          1:       raw = 24'hFFFFFF;
          2:       raw = 24'h800000;
          3:       raw = 24'h7FFFFF;
          default: raw = sample_t'($urandom);
        endcase
        queue_request(raw, secs, feed_calm ? 0 : $urandom_range(0, MAX_WAIT));
      end
      if (seg == 6)
        hold_asked++;
    end

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests and checked %0d results across %0d closed seconds.",
             requests_sent, results_seen, seconds_closed);
    $display("Traffic mixed sample extremes, seconds wraparound, bursts and a long stall.");
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
